[rtl/pid_dz_pkg.sv]
`default_nettype none

package pid_dz_pkg;

    // APB address width: six word registers at byte addresses 0 to 20
    localparam int unsigned ApbAw = 5;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_GAIN_P         = 3'd0;
    localparam logic [2:0] REG_GAIN_I         = 3'd1;
    localparam logic [2:0] REG_GAIN_D         = 3'd2;
    localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd3;
    localparam logic [2:0] REG_OUTPUT_LIMIT   = 3'd4;
    localparam logic [2:0] REG_DEAD_BAND      = 3'd5;

    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // Q32.32 product to Q16.16: floor shift by 16, then saturate to 32 bits
    function automatic logic signed [31:0] qsat(input logic signed [64:0] prod);
        logic signed [31:0] res;
        if ((&prod[64:47]) || !(|prod[64:47])) begin
            res = prod[47:16];
        end else if (prod[64]) begin
            res = Q_MIN;
        end else begin
            res = Q_MAX;
        end
        return res;
    endfunction

    // clamp to +-lim; lim is at most 2^31-1 so the result fits 32 bits
    function automatic logic signed [31:0] clamp_sym(input logic signed [33:0] v,
                                                     input logic [30:0] lim);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        logic signed [31:0] res;
        hi = $signed({3'b000, lim});
        lo = -hi;
        if (v > hi) begin
            res = hi[31:0];
        end else if (v < lo) begin
            res = lo[31:0];
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/pid_loop_with_deadzone_top.sv]
// Positional PID loop with error dead band, signed Q16.16.
// Input channel (i_in_valid / o_in_ready) carries setpoint, measured value
// and a clear flag; the output channel (o_out_valid / i_out_ready) carries
// one clamped drive value per input item, in order.
// Gains, limits and the dead band sit in an APB register file (word
// registers at byte addresses 0..20); write them only while the loop idles.
// The datapath is a seven-register pipeline: input, error, derivative
// difference, products, scaled terms, integral update, output. One item is
// taken every cycle except while input is refused, as described below.
// The error history and the integral accumulator are updated in a single
// stage each, so consecutive items see each other's state.
// A clear item zeroes error history and integral and gives a drive of 0.
// Each stage carries a valid bit and stalls only when it is full and the
// stage after it cannot move, so bubbles are squeezed out while the
// receiver stalls; input is refused only while all seven stages hold items
// and the receiver stalls.
// Reset empties the pipeline and clears registers, history and integral.
`default_nettype none

module pid_loop_with_deadzone_top
    import pid_dz_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,

    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ApbAw-1:0]    paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,

    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic signed [31:0]  i_setpoint,
    input  wire logic signed [31:0]  i_measured,
    input  wire logic                i_clear_history,

    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic signed [31:0]       o_drive
);

    // configuration
    logic signed [31:0] r_gain_p;
    logic signed [31:0] r_gain_i;
    logic signed [31:0] r_gain_d;
    logic        [30:0] r_integral_limit;
    logic        [30:0] r_output_limit;
    logic        [30:0] r_dead_band;
    logic               cfg_wr;
    logic        [2:0]  cfg_idx;

    // pipeline
    logic               r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic               rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

    logic signed [31:0] r_sp1, r_fb1;
    logic               r_clr1;

    logic signed [32:0] diff;
    logic        [32:0] mag;
    logic signed [31:0] n_err2;
    logic signed [31:0] r_err2;
    logic               r_clr2;

    logic signed [32:0] n_dd3;
    logic signed [32:0] r_dd3;
    logic signed [31:0] r_err3;   // also the error history
    logic               r_clr3;

    logic signed [63:0] n_prod_p4, n_prod_i4;
    logic signed [64:0] n_prod_d4;
    logic signed [63:0] r_prod_p4, r_prod_i4;
    logic signed [64:0] r_prod_d4;
    logic               r_clr4;

    logic signed [31:0] r_tp5, r_ti5, r_td5;
    logic               r_clr5;

    logic signed [33:0] integ_sum;
    logic signed [31:0] n_integ;
    logic signed [31:0] r_integ;  // also the integral accumulator
    logic signed [32:0] r_dp6;
    logic               r_clr6;

    logic signed [33:0] total;
    logic signed [31:0] n_drive;
    logic signed [31:0] r_drive;

    // ---------------- register file ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p         <= '0;
            r_gain_i         <= '0;
            r_gain_d         <= '0;
            r_integral_limit <= '0;
            r_output_limit   <= '0;
            r_dead_band      <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_GAIN_P:         r_gain_p         <= pwdata;
                REG_GAIN_I:         r_gain_i         <= pwdata;
                REG_GAIN_D:         r_gain_d         <= pwdata;
                REG_INTEGRAL_LIMIT: r_integral_limit <= pwdata[30:0];
                REG_OUTPUT_LIMIT:   r_output_limit   <= pwdata[30:0];
                REG_DEAD_BAND:      r_dead_band      <= pwdata[30:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_GAIN_P:         prdata = r_gain_p;
            REG_GAIN_I:         prdata = r_gain_i;
            REG_GAIN_D:         prdata = r_gain_d;
            REG_INTEGRAL_LIMIT: prdata = {1'b0, r_integral_limit};
            REG_OUTPUT_LIMIT:   prdata = {1'b0, r_output_limit};
            REG_DEAD_BAND:      prdata = {1'b0, r_dead_band};
            default:            prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    // a stage moves when it is empty or the next one moves
    assign rdy7 = !r_v7 || i_out_ready;
    assign rdy6 = !r_v6 || rdy7;
    assign rdy5 = !r_v5 || rdy6;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign o_in_ready  = rdy1;
    assign o_out_valid = r_v7;
    assign o_drive     = r_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_in_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
            if (rdy6) r_v6 <= r_v5;
            if (rdy7) r_v7 <= r_v6;
        end
    end

    // ---------------- stage 1: input register ----------------
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_in_valid) begin
            r_sp1  <= i_setpoint;
            r_fb1  <= i_measured;
            r_clr1 <= i_clear_history;
        end
    end

    // ---------------- stage 2: error with dead band ----------------
    always_comb begin
        diff = {r_sp1[31], r_sp1} - {r_fb1[31], r_fb1};
        mag  = diff[32] ? 33'(-diff) : 33'(diff);
        if (mag < {2'b00, r_dead_band}) begin
            n_err2 = '0;
        end else if (diff[32] != diff[31]) begin
            n_err2 = diff[32] ? Q_MIN : Q_MAX;
        end else begin
            n_err2 = diff[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_err2 <= n_err2;
            r_clr2 <= r_clr1;
        end
    end

    // ---------------- stage 3: derivative difference, error history ----------------
    assign n_dd3 = {r_err2[31], r_err2} - {r_err3[31], r_err3};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err3 <= '0;
        end else if (rdy3 && r_v2) begin
            r_err3 <= r_clr2 ? 32'sd0 : r_err2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            r_dd3  <= n_dd3;
            r_clr3 <= r_clr2;
        end
    end

    // ---------------- stage 4: products ----------------
    assign n_prod_p4 = r_err3 * r_gain_p;
    assign n_prod_i4 = r_err3 * r_gain_i;
    assign n_prod_d4 = r_dd3 * r_gain_d;

    always_ff @(posedge i_clk) begin
        if (rdy4 && r_v3) begin
            r_prod_p4 <= n_prod_p4;
            r_prod_i4 <= n_prod_i4;
            r_prod_d4 <= n_prod_d4;
            r_clr4    <= r_clr3;
        end
    end

    // ---------------- stage 5: scale and saturate terms ----------------
    always_ff @(posedge i_clk) begin
        if (rdy5 && r_v4) begin
            r_tp5  <= qsat({r_prod_p4[63], r_prod_p4});
            r_ti5  <= qsat({r_prod_i4[63], r_prod_i4});
            r_td5  <= qsat(r_prod_d4);
            r_clr5 <= r_clr4;
        end
    end

    // ---------------- stage 6: integral update ----------------
    always_comb begin
        integ_sum = {{2{r_integ[31]}}, r_integ} + {{2{r_ti5[31]}}, r_ti5};
        n_integ   = r_clr5 ? 32'sd0 : clamp_sym(integ_sum, r_integral_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (rdy6 && r_v5) begin
            r_integ <= n_integ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy6 && r_v5) begin
            r_dp6  <= {r_td5[31], r_td5} + {r_tp5[31], r_tp5};
            r_clr6 <= r_clr5;
        end
    end

    // ---------------- stage 7: output clamp ----------------
    always_comb begin
        total   = {r_dp6[32], r_dp6} + {{2{r_integ[31]}}, r_integ};
        n_drive = r_clr6 ? 32'sd0 : clamp_sym(total, r_output_limit);
    end

    always_ff @(posedge i_clk) begin
        if (rdy7 && r_v6) begin
            r_drive <= n_drive;
        end
    end

endmodule

`default_nettype wire
